/* design/bstseq_pkg.sv */
`default_nettype none

package bstseq_pkg;

    localparam int DIGIT_COUNT      = 6;
    localparam int UP_SEGMENT_BIT   = 8;
    localparam int DOWN_SEGMENT_BIT = 9;
    localparam int NUM_OUTPUTS      = 6;

    localparam logic [11:0] LAMP_MIN        = 12'd50;
    localparam logic [11:0] LAMP_MAX        = 12'd2000;
    localparam logic [11:0] BUZ_MIN         = 12'd20;
    localparam logic [11:0] BUZ_MAX         = 12'd300;
    localparam logic [31:0] BATTERY_REFRESH = 32'd500;
    localparam logic [15:0] ALL_SEGMENTS    = 16'h00FF;
    localparam logic [7:0]  KEY_BITS        = 8'h1F;

    localparam logic [15:0] RST_BLANK_TIME  = 16'd500;
    localparam logic [15:0] RST_STEP_PERIOD = 16'd250;
    localparam logic [15:0] RST_PAGE_PERIOD = 16'd1000;
    localparam logic [15:0] RST_RAW_PERIOD  = 16'd100;
    localparam logic [15:0] RST_KEY_HOLD    = 16'd1000;
    localparam logic [7:0]  RST_BUZZERS     = 8'h30;
    localparam logic [7:0]  RST_LAMPS       = 8'h0F;

    typedef enum logic [3:0] {
        MODE_DISABLED = 4'd0,
        MODE_STARTUP  = 4'd1,
        MODE_SEGMENT  = 4'd2,
        MODE_UP       = 4'd3,
        MODE_DOWN     = 4'd4,
        MODE_DIGITS   = 4'd5,
        MODE_RAW      = 4'd6,
        MODE_BATTERY  = 4'd7,
        MODE_KEY      = 4'd8,
        MODE_ERROR    = 4'd9
    } mode_t;

    typedef enum logic [3:0] {
        RND_NONE    = 4'd0,
        RND_CLEAR   = 4'd1,
        RND_SINGLE  = 4'd2,
        RND_DIGITS  = 4'd3,
        RND_CONFIG  = 4'd4,
        RND_RAW     = 4'd5,
        RND_BATTERY = 4'd6,
        RND_KEY     = 4'd7,
        RND_FLUSH   = 4'd8
    } render_t;

    typedef enum logic [1:0] {
        DRV_NONE    = 2'd0,
        DRV_ON      = 2'd1,
        DRV_OFF     = 2'd2,
        DRV_ALL_OFF = 2'd3
    } drive_t;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_TEST    = 3'd1,
        ACT_SELECT  = 3'd2,
        ACT_KEY     = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_FAULT   = 3'd5,
        ACT_ALL_OFF = 3'd6,
        ACT_START   = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        CFG_BLANK_TIME  = 3'd0,
        CFG_STEP_PERIOD = 3'd1,
        CFG_PAGE_PERIOD = 3'd2,
        CFG_RAW_PERIOD  = 3'd3,
        CFG_KEY_HOLD    = 3'd4,
        CFG_BUZZERS     = 3'd5,
        CFG_LAMPS       = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic [2:0]  output_id;
        logic [11:0] on_time_ms;
        logic        lamp_only;
        logic        view;
        logic [7:0]  key_bits;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic        running;
        logic [3:0]  render_cmd;
        logic [2:0]  render_digit;
        logic [15:0] render_segments;
        logic [1:0]  drive_cmd;
        logic [2:0]  drive_output;
        logic        test_busy;
        logic        accepted;
        logic [4:0]  key_state;
    } out_item_t;

endpackage

`default_nettype wire

/* design/board_self_test_sequencer_top.sv */
// Board self-test sequencer.
// Input channel s_valid/s_ready/s_data carries one timestamped event per beat
// (tick, output test, view select, key, stop, fault, all off, start).
// Output channel m_valid/m_ready/m_data returns exactly one render/drive
// result per input beat, in order.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// timing and output-class registers; cfg_ready is always high. Write only
// while idle. Indexes past the last register are ignored.
// Path: a beat taken into the input register is processed combinationally
// and its result is written to the result register that drives m_.
// Throughput: one beat per cycle unless m_ready stalls, set by the single
// input-to-result register pass, which also updates the sequencer state.
// Reset (aresetn low, synchronous): both registers empty, sequencer disabled,
// configuration at its defaults.
// When the receiver stalls, the result register holds and the input register
// takes one more beat; s_ready then drops until m_ready returns.
`default_nettype none

module board_self_test_sequencer_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire bstseq_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bstseq_pkg::out_item_t      m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [15:0]           cfg_data
);
    import bstseq_pkg::*;

    // configuration
    logic [15:0] blank_time_reg, step_period_reg, page_period_reg;
    logic [15:0] raw_period_reg, key_hold_reg;
    logic [7:0]  buzzers_reg, lamps_reg;

    // pipeline
    logic      in_valid_reg, m_valid_reg;
    in_item_t  in_reg;
    out_item_t m_data_reg, res;
    logic      out_free, advance;

    // sequencer state
    mode_t       cur_mode_reg, mode_next;
    logic        active_reg, active_next;
    logic [31:0] entry_time_reg, entry_time_next;
    logic [31:0] render_time_reg, render_time_next;
    logic [31:0] pulse_start_reg, pulse_start_next;
    logic [11:0] pulse_len_reg, pulse_len_next;
    logic [31:0] key_time_reg, key_time_next;
    logic [2:0]  step_reg, step_next;
    logic        page_reg, page_next;
    logic        busy_reg, busy_next;
    logic [2:0]  pulse_out_reg, pulse_out_next;
    logic [4:0]  keys_reg, keys_next;

    // combinational helpers
    logic [31:0] d_entry, d_render, d_key, d_pulse;
    logic        blank_done, step_done, page_done, raw_done, batt_done;
    logic        key_done, pulse_done;
    logic [3:0]  next_pos;
    logic        do_enter;
    mode_t       enter_sel;
    mode_t       walk_next;
    logic        id_ok, lamp_ok, dur_ok;

    function automatic logic [15:0] walk_pattern(input mode_t m);
        logic [15:0] p;
        if (m == MODE_SEGMENT) begin
            p = ALL_SEGMENTS;
        end else if (m == MODE_UP) begin
            p = 16'(1) << UP_SEGMENT_BIT;
        end else begin
            p = 16'(1) << DOWN_SEGMENT_BIT;
        end
        return p;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_time_reg  <= RST_BLANK_TIME;
            step_period_reg <= RST_STEP_PERIOD;
            page_period_reg <= RST_PAGE_PERIOD;
            raw_period_reg  <= RST_RAW_PERIOD;
            key_hold_reg    <= RST_KEY_HOLD;
            buzzers_reg     <= RST_BUZZERS;
            lamps_reg       <= RST_LAMPS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BLANK_TIME:  blank_time_reg  <= cfg_data;
                CFG_STEP_PERIOD: step_period_reg <= cfg_data;
                CFG_PAGE_PERIOD: page_period_reg <= cfg_data;
                CFG_RAW_PERIOD:  raw_period_reg  <= cfg_data;
                CFG_KEY_HOLD:    key_hold_reg    <= cfg_data;
                CFG_BUZZERS:     buzzers_reg     <= cfg_data[7:0];
                CFG_LAMPS:       lamps_reg       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode_reg    <= MODE_DISABLED;
            active_reg      <= 1'b0;
            entry_time_reg  <= '0;
            render_time_reg <= '0;
            pulse_start_reg <= '0;
            pulse_len_reg   <= '0;
            key_time_reg    <= '0;
            step_reg        <= '0;
            page_reg        <= 1'b0;
            busy_reg        <= 1'b0;
            pulse_out_reg   <= 3'(NUM_OUTPUTS);
            keys_reg        <= '0;
        end else if (advance) begin
            cur_mode_reg    <= mode_next;
            active_reg      <= active_next;
            entry_time_reg  <= entry_time_next;
            render_time_reg <= render_time_next;
            pulse_start_reg <= pulse_start_next;
            pulse_len_reg   <= pulse_len_next;
            key_time_reg    <= key_time_next;
            step_reg        <= step_next;
            page_reg        <= page_next;
            busy_reg        <= busy_next;
            pulse_out_reg   <= pulse_out_next;
            keys_reg        <= keys_next;
        end
    end

    // wrapping elapsed-time checks
    assign d_entry    = in_reg.now_ms - entry_time_reg;
    assign d_render   = in_reg.now_ms - render_time_reg;
    assign d_key      = in_reg.now_ms - key_time_reg;
    assign d_pulse    = in_reg.now_ms - pulse_start_reg;
    assign blank_done = d_entry >= {16'd0, blank_time_reg};
    assign step_done  = d_entry >= {16'd0, step_period_reg};
    assign page_done  = d_entry >= {16'd0, page_period_reg};
    assign raw_done   = d_render >= {16'd0, raw_period_reg};
    assign batt_done  = d_render >= BATTERY_REFRESH;
    assign key_done   = d_key >= {16'd0, key_hold_reg};
    assign pulse_done = d_pulse >= {20'd0, pulse_len_reg};

    assign next_pos  = {1'b0, step_reg} + 4'd1;
    assign walk_next = (cur_mode_reg == MODE_SEGMENT) ? MODE_UP :
                       (cur_mode_reg == MODE_UP) ? MODE_DOWN : MODE_DIGITS;

    assign id_ok   = {1'b0, in_reg.output_id} < 4'(NUM_OUTPUTS);
    assign lamp_ok = !in_reg.lamp_only || lamps_reg[in_reg.output_id];
    assign dur_ok  = buzzers_reg[in_reg.output_id] ?
                     (in_reg.on_time_ms >= BUZ_MIN && in_reg.on_time_ms <= BUZ_MAX) :
                     (in_reg.on_time_ms >= LAMP_MIN && in_reg.on_time_ms <= LAMP_MAX);

    always_comb begin
        mode_next        = cur_mode_reg;
        active_next      = active_reg;
        entry_time_next  = entry_time_reg;
        render_time_next = render_time_reg;
        pulse_start_next = pulse_start_reg;
        pulse_len_next   = pulse_len_reg;
        key_time_next    = key_time_reg;
        step_next        = step_reg;
        page_next        = page_reg;
        busy_next        = busy_reg;
        pulse_out_next   = pulse_out_reg;
        keys_next        = keys_reg;
        do_enter         = 1'b0;
        enter_sel        = MODE_STARTUP;
        res              = '0;

        case (in_reg.action)
            ACT_TICK: begin
                if (active_reg) begin
                    if (busy_reg && pulse_done) begin
                        res.drive_cmd    = DRV_OFF;
                        res.drive_output = pulse_out_reg;
                        busy_next        = 1'b0;
                        pulse_out_next   = 3'(NUM_OUTPUTS);
                    end
                    case (cur_mode_reg)
                        MODE_STARTUP: begin
                            if (blank_done) begin
                                do_enter  = 1'b1;
                                enter_sel = MODE_SEGMENT;
                            end
                        end
                        MODE_SEGMENT, MODE_UP, MODE_DOWN: begin
                            if (step_done) begin
                                step_next = next_pos[2:0];
                                if (next_pos < 4'(DIGIT_COUNT)) begin
                                    entry_time_next     = in_reg.now_ms;
                                    res.render_cmd      = RND_SINGLE;
                                    res.render_digit    = next_pos[2:0];
                                    res.render_segments = walk_pattern(cur_mode_reg);
                                end else begin
                                    do_enter  = 1'b1;
                                    enter_sel = walk_next;
                                end
                            end
                        end
                        MODE_DIGITS: begin
                            if (page_done) begin
                                entry_time_next = in_reg.now_ms;
                                if (!page_reg) begin
                                    page_next      = 1'b1;
                                    res.render_cmd = RND_CONFIG;
                                end else begin
                                    do_enter  = 1'b1;
                                    enter_sel = MODE_RAW;
                                end
                            end
                        end
                        MODE_RAW: begin
                            if (raw_done) begin
                                render_time_next = in_reg.now_ms;
                                res.render_cmd   = RND_RAW;
                            end
                        end
                        MODE_BATTERY: begin
                            if (batt_done) begin
                                render_time_next = in_reg.now_ms;
                                res.render_cmd   = RND_BATTERY;
                            end
                        end
                        MODE_KEY: begin
                            if (key_done) begin
                                do_enter  = 1'b1;
                                enter_sel = MODE_RAW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ACT_TEST: begin
                if (active_reg && !busy_reg && lamp_ok && id_ok && dur_ok) begin
                    pulse_start_next = in_reg.now_ms;
                    pulse_len_next   = in_reg.on_time_ms;
                    busy_next        = 1'b1;
                    pulse_out_next   = in_reg.output_id;
                    res.drive_cmd    = DRV_ON;
                    res.drive_output = in_reg.output_id;
                    res.accepted     = 1'b1;
                end
            end
            ACT_SELECT: begin
                if (active_reg) begin
                    do_enter     = 1'b1;
                    enter_sel    = in_reg.view ? MODE_BATTERY : MODE_RAW;
                    res.accepted = 1'b1;
                end
            end
            ACT_KEY: begin
                keys_next = 5'(in_reg.key_bits & KEY_BITS);
                if (active_reg && (cur_mode_reg inside {MODE_RAW, MODE_BATTERY, MODE_KEY}))
                begin
                    key_time_next  = in_reg.now_ms;
                    mode_next      = MODE_KEY;
                    res.render_cmd = RND_KEY;
                end
            end
            ACT_STOP, ACT_FAULT: begin
                res.drive_cmd  = DRV_ALL_OFF;
                res.render_cmd = RND_FLUSH;
                busy_next      = 1'b0;
                pulse_out_next = 3'(NUM_OUTPUTS);
                active_next    = 1'b0;
                mode_next      = (in_reg.action == ACT_FAULT) ? MODE_ERROR : MODE_DISABLED;
            end
            ACT_ALL_OFF: begin
                res.drive_cmd  = DRV_ALL_OFF;
                busy_next      = 1'b0;
                pulse_out_next = 3'(NUM_OUTPUTS);
            end
            default: begin
                // start: abandon any running pulse
                if (busy_reg) begin
                    res.drive_cmd    = DRV_OFF;
                    res.drive_output = pulse_out_reg;
                end
                keys_next      = '0;
                busy_next      = 1'b0;
                pulse_out_next = 3'(NUM_OUTPUTS);
                pulse_len_next = '0;
                active_next    = 1'b1;
                do_enter       = 1'b1;
                enter_sel      = MODE_STARTUP;
            end
        endcase

        if (do_enter) begin
            mode_next        = enter_sel;
            entry_time_next  = in_reg.now_ms;
            render_time_next = in_reg.now_ms;
            step_next        = '0;
            case (enter_sel)
                MODE_STARTUP: res.render_cmd = RND_CLEAR;
                MODE_SEGMENT, MODE_UP, MODE_DOWN: begin
                    res.render_cmd      = RND_SINGLE;
                    res.render_digit    = '0;
                    res.render_segments = walk_pattern(enter_sel);
                end
                MODE_DIGITS: begin
                    page_next      = 1'b0;
                    res.render_cmd = RND_DIGITS;
                end
                MODE_RAW:     res.render_cmd = RND_RAW;
                MODE_BATTERY: res.render_cmd = RND_BATTERY;
                MODE_KEY:     res.render_cmd = RND_KEY;
                default: ;
            endcase
        end

        res.mode      = mode_next;
        res.running   = active_next;
        res.test_busy = busy_next;
        res.key_state = keys_next;
    end

    a_busy_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> active_reg)
        else $error("pulse busy while sequencer inactive");

    a_idle_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (cur_mode_reg == MODE_DISABLED || cur_mode_reg == MODE_ERROR))
        else $error("inactive sequencer in a running mode");

    a_drive_on_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.drive_cmd == DRV_ON)
            |-> (m_data_reg.accepted && m_data_reg.test_busy))
        else $error("output switched on without an accepted pulse");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.render_cmd == RND_SINGLE)
            |-> ({1'b0, m_data_reg.render_digit} < 4'(DIGIT_COUNT)))
        else $error("single digit render beyond last digit");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
